// ===== src/fss_pkg.sv =====
// Shared constants, types and character helpers for the fuzzy subsequence scorer.
`timescale 1ns / 1ps

package fss_pkg;

	localparam int MAX_QUERY = 64;
	localparam int QA_W      = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
	localparam int QL_W      = $clog2(MAX_QUERY + 1);
	localparam int SCORE_W   = 13;
	localparam int GAP_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 8;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TEXT   = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_POINTS  = 3'd0,
		REG_CONTIG_BONUS  = 3'd1,
		REG_WORD_BONUS    = 3'd2,
		REG_FIRST_BONUS   = 3'd3,
		REG_GAP_STEP      = 3'd4,
		REG_GAP_CAP       = 3'd5
	} reg_idx_t;

	// ASCII case folding: upper-case letters map to lower case.
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	// Bytes that end a word: space - _ / . @ :
	function automatic logic is_boundary(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2F) ||
		       (c == 8'h2E) || (c == 8'h40) || (c == 8'h3A);
	endfunction

endpackage

// ===== src/fuzzy_subsequence_scorer.sv =====
// Top level of the fuzzy subsequence scorer: query memory, scan state and result register.
`timescale 1ns / 1ps

// Usage
// The slave stream carries commands: tuser selects clear query, append query byte,
// text byte or end of text; tdata is the byte; tlast marks the final text byte.
// A query is loaded first, one transfer per character, into a 64-entry memory;
// characters beyond its depth are dropped. Text bytes are then streamed and matched
// greedily against the query with ASCII case folding. Loading or clearing the query
// abandons any text in progress without a result.
// The master stream returns one transfer per text: the score in tdata and, in tuser,
// a flag that is set when the whole query was found.
// A result is registered in the output register in the cycle after the transfer
// that ends the text. The query character under comparison is read from the memory
// ahead of use, addressed by the next query position, so one text byte per cycle is
// sustained while the output does not stall; the write port of the memory forwards to the
// read port when an append lands on the entry being fetched.
// When the receiver stalls, the result is held in the output register and tready
// stays low, so no further transfer is taken until the held result has left.
// Reset clears the query length, the scan state and the output valid flag, and returns the
// scoring registers to their defaults; the memory contents are not cleared. The user must
// write scoring registers via the plain write port while the block is idle (unchecked).
module fuzzy_subsequence_scorer (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port
	input  logic                           cfg_we,
	input  logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fss_pkg::CFG_DAT_W-1:0]  cfg_data,
	// Command stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // [7:0] ch
	input  logic [1:0]                     s_axis_tuser,   // [1:0] cmd
	input  logic                           s_axis_tlast,
	// Result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [15:0]                    m_axis_tdata,   // [12:0] score, [15:13] zero
	output logic                           m_axis_tuser    // [0] matched
);

	import fss_pkg::*;

	// Scoring registers.
	logic [4:0]       match_points_q, contig_bonus_q, word_bonus_q, first_bonus_q;
	logic [2:0]       gap_step_q;
	logic [GAP_W-1:0] gap_cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_points_q <= 5'd8;
			contig_bonus_q <= 5'd10;
			word_bonus_q   <= 5'd12;
			first_bonus_q  <= 5'd16;
			gap_step_q     <= 3'd1;
			gap_cap_q      <= 8'd40;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MATCH_POINTS: match_points_q <= cfg_data[4:0];
				REG_CONTIG_BONUS: contig_bonus_q <= cfg_data[4:0];
				REG_WORD_BONUS:   word_bonus_q   <= cfg_data[4:0];
				REG_FIRST_BONUS:  first_bonus_q  <= cfg_data[4:0];
				REG_GAP_STEP:     gap_step_q     <= cfg_data[2:0];
				REG_GAP_CAP:      gap_cap_q      <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Scan state.
	logic [QL_W-1:0]    qlen_q, qpos_q;
	logic [SCORE_W-1:0] run_q;
	logic [GAP_W-1:0]   gap_q;
	logic               prev_match_q, at_start_q;
	logic [7:0]         prev_byte_q;

	// Output register.
	logic               out_valid_q;
	logic [SCORE_W-1:0] out_score_q;
	logic               out_matched_q;

	// Query memory; qchar_q always holds the entry at qpos_q.
	logic [7:0] qmem [MAX_QUERY];
	logic [7:0] qchar_q;

	logic accept;
	cmd_t cmd;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cmd           = cmd_t'(s_axis_tuser);

	// Per-byte scoring of a text byte against the current query character.
	logic               active, hit;
	logic [6:0]         add;
	logic [SCORE_W:0]   run_sum;
	logic [SCORE_W-1:0] run_hit;
	logic [GAP_W:0]     gap_sum;
	logic [GAP_W-1:0]   gap_miss;

	assign active = qpos_q < qlen_q;
	assign hit    = fold_case(s_axis_tdata) == fold_case(qchar_q);

	always_comb begin
		add = 7'(match_points_q);
		if (at_start_q) begin
			add = add + 7'(first_bonus_q);
		end else if (is_boundary(prev_byte_q)) begin
			add = add + 7'(word_bonus_q);
		end
		if (prev_match_q) begin
			add = add + 7'(contig_bonus_q);
		end
	end

	assign run_sum  = {1'b0, run_q} + (SCORE_W+1)'(add);
	assign run_hit  = run_sum[SCORE_W] ? SCORE_MAX : run_sum[SCORE_W-1:0];
	assign gap_sum  = {1'b0, gap_q} + (GAP_W+1)'(gap_step_q);
	assign gap_miss = (gap_sum > {1'b0, gap_cap_q}) ? gap_cap_q : gap_sum[GAP_W-1:0];

	// Next state.
	logic [QL_W-1:0]    qlen_d, qpos_d;
	logic [SCORE_W-1:0] run_d;
	logic [GAP_W-1:0]   gap_d;
	logic               prev_match_d, at_start_d;
	logic [7:0]         prev_byte_d;
	logic               finish, restart, mem_we;

	always_comb begin
		qlen_d       = qlen_q;
		qpos_d       = qpos_q;
		run_d        = run_q;
		gap_d        = gap_q;
		prev_match_d = prev_match_q;
		prev_byte_d  = prev_byte_q;
		at_start_d   = at_start_q;
		finish       = 1'b0;
		restart      = 1'b0;
		mem_we       = 1'b0;
		if (accept) begin
			unique case (cmd)
				CMD_CLEAR: begin
					qlen_d  = '0;
					restart = 1'b1;
				end
				CMD_APPEND: begin
					if (qlen_q < QL_W'(MAX_QUERY)) begin
						mem_we = 1'b1;
						qlen_d = qlen_q + 1'b1;
					end
					restart = 1'b1;
				end
				CMD_TEXT: begin
					if (active) begin
						if (hit) begin
							run_d        = run_hit;
							prev_match_d = 1'b1;
							qpos_d       = qpos_q + 1'b1;
						end else begin
							prev_match_d = 1'b0;
							gap_d        = gap_miss;
						end
					end
					prev_byte_d = s_axis_tdata;
					at_start_d  = 1'b0;
					finish      = s_axis_tlast;
				end
				CMD_END: begin
					finish = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Final score from the state after this byte.
	logic               res_matched;
	logic [GAP_W-1:0]   pen;
	logic [SCORE_W-1:0] res_score;

	always_comb begin
		pen         = (gap_d < gap_cap_q) ? gap_d : gap_cap_q;
		res_matched = 1'b0;
		res_score   = '0;
		if (qlen_q == '0) begin
			res_matched = 1'b1;
		end else if (qpos_d >= qlen_q) begin
			res_matched = 1'b1;
			res_score   = (run_d > SCORE_W'(pen)) ? run_d - SCORE_W'(pen) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q       <= '0;
			qpos_q       <= '0;
			run_q        <= '0;
			gap_q        <= '0;
			prev_match_q <= 1'b0;
			prev_byte_q  <= '0;
			at_start_q   <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			qlen_q <= qlen_d;
			if (restart || finish) begin
				qpos_q       <= '0;
				run_q        <= '0;
				gap_q        <= '0;
				prev_match_q <= 1'b0;
				prev_byte_q  <= '0;
				at_start_q   <= 1'b1;
			end else begin
				qpos_q       <= qpos_d;
				run_q        <= run_d;
				gap_q        <= gap_d;
				prev_match_q <= prev_match_d;
				prev_byte_q  <= prev_byte_d;
				at_start_q   <= at_start_d;
			end
			out_valid_q <= finish || (out_valid_q && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_score_q   <= res_score;
			out_matched_q <= res_matched;
		end
	end

	// Memory: one write and one read a cycle. The read fetches the entry for the
	// position the scan will hold next cycle, with the write data forwarded on a clash.
	logic [QA_W-1:0] wr_addr, rd_addr;
	assign wr_addr = qlen_q[QA_W-1:0];
	assign rd_addr = (restart || finish) ? '0 : qpos_d[QA_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			qmem[wr_addr] <= s_axis_tdata;
		end
		if (mem_we && (wr_addr == rd_addr)) begin
			qchar_q <= s_axis_tdata;
		end else begin
			qchar_q <= qmem[rd_addr];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = 16'(out_score_q);
	assign m_axis_tuser  = out_matched_q;

`ifndef SYNTHESIS
	a_pos_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		qpos_q <= qlen_q)
		else $error("query position beyond query length");

	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		qlen_q <= QL_W'(MAX_QUERY))
		else $error("query length beyond memory depth");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("no-match result carries a non-zero score");

	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_CLEAR) |=> (qlen_q == '0 && qpos_q == '0))
		else $error("clear did not empty the query");
`endif

endmodule

// ===== test/fss_score_model_pkg.sv =====
// Scoring predictor and result scoreboard used by the fuzzy subsequence scorer testbench.
`timescale 1ns / 1ps

package fss_score_model_pkg;

	import fss_pkg::*;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               matched;
	} verdict_t;

	class score_predictor;
		logic [4:0] match_pts;
		logic [4:0] contig_bonus;
		logic [4:0] word_bonus;
		logic [4:0] first_bonus;
		logic [2:0] gap_step;
		logic [7:0] gap_cap;

		logic [7:0] query_chars [MAX_QUERY];
		int         query_len;
		int         query_idx;
		int         score_acc;
		int         gap_sum;
		bit         prev_hit;
		bit         at_start;
		logic [7:0] prev_char;

		verdict_t   verdicts [$];
		int         errors;

		function new();
			match_pts    = 5'd8;
			contig_bonus = 5'd10;
			word_bonus   = 5'd12;
			first_bonus  = 5'd16;
			gap_step     = 3'd1;
			gap_cap      = 8'd40;
			query_len    = 0;
			errors       = 0;
			restart_scan();
		endfunction

		function void restart_scan();
			query_idx = 0;
			score_acc = 0;
			gap_sum   = 0;
			prev_hit  = 1'b0;
			at_start  = 1'b1;
			prev_char = 8'h00;
		endfunction

		function logic [7:0] fold(logic [7:0] c);
			return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		endfunction

		function bit word_break(logic [7:0] c);
			return c == " " || c == "-" || c == "_" || c == "/" || c == "." ||
			       c == "@" || c == ":";
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_MATCH_POINTS: match_pts    = val[4:0];
				REG_CONTIG_BONUS: contig_bonus = val[4:0];
				REG_WORD_BONUS:   word_bonus   = val[4:0];
				REG_FIRST_BONUS:  first_bonus  = val[4:0];
				REG_GAP_STEP:     gap_step     = val[2:0];
				REG_GAP_CAP:      gap_cap      = val;
				default: ;
			endcase
		endfunction

		// The penalty is limited again by the cap in force when the text ends.
		function void close_text();
			verdict_t v;
			int       pen;
			v.score   = '0;
			v.matched = 1'b0;
			if (query_len == 0) begin
				v.matched = 1'b1;
			end else if (query_idx >= query_len) begin
				v.matched = 1'b1;
				pen = (gap_sum < gap_cap) ? gap_sum : int'(gap_cap);
				v.score = (score_acc > pen) ? SCORE_W'(score_acc - pen) : '0;
			end
			verdicts.push_back(v);
			restart_scan();
		endfunction

		function void note_command(cmd_t cmd, logic [7:0] ch, logic last);
			int add;
			case (cmd)
				CMD_CLEAR: begin
					query_len = 0;
					restart_scan();
				end
				CMD_APPEND: begin
					if (query_len < MAX_QUERY) begin
						query_chars[query_len] = ch;
						query_len++;
					end
					restart_scan();
				end
				CMD_TEXT: begin
					if (query_idx < query_len) begin
						if (fold(ch) == fold(query_chars[query_idx])) begin
							add = match_pts;
							if (at_start) begin
								add += first_bonus;
							end else if (word_break(prev_char)) begin
								add += word_bonus;
							end
							if (prev_hit) begin
								add += contig_bonus;
							end
							score_acc += add;
							if (score_acc > SCORE_MAX) begin
								score_acc = SCORE_MAX;
							end
							prev_hit = 1'b1;
							query_idx++;
						end else begin
							prev_hit = 1'b0;
							gap_sum += gap_step;
							if (gap_sum > gap_cap) begin
								gap_sum = gap_cap;
							end
						end
					end
					prev_char = ch;
					at_start  = 1'b0;
					if (last) begin
						close_text();
					end
				end
				default: close_text();
			endcase
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_verdict(logic [15:0] data, logic flag);
			verdict_t want;
			if (verdicts.size() == 0) begin
				report($sformatf("result with none outstanding: score %0d matched %0b",
				                 data[SCORE_W-1:0], flag));
				return;
			end
			want = verdicts.pop_front();
			if (data[SCORE_W-1:0] !== want.score) begin
				report($sformatf("score %0d, predicted %0d", data[SCORE_W-1:0], want.score));
			end
			if (data[15:SCORE_W] !== '0) begin
				report($sformatf("padding bits of tdata are %b", data[15:SCORE_W]));
			end
			if (flag !== want.matched) begin
				report($sformatf("matched flag %b, predicted %b", flag, want.matched));
			end
		endtask
	endclass

endpackage

// ===== test/fuzzy_subsequence_scorer_tb.sv =====
// Self-checking testbench for the fuzzy subsequence scorer top level.
`timescale 1ns / 1ps

// The command stream is driven by plain tasks: a short directed opening that visits the
// empty query, the empty text, case folding, every bonus, a query change mid-text and a
// cap lowered mid-text, then random episodes of query loads followed by texts. Most
// texts are built to contain the loaded query as a subsequence with random filler, so
// that scans reach the end of the query; the rest are random bytes or stray commands.
// A monitor samples both streams at every rising edge. Each accepted command transfer
// is fed to the scoring predictor, which queues the verdict that a text end must give;
// each result transfer is compared field by field with the oldest queued verdict.
module fuzzy_subsequence_scorer_tb;

	import fss_pkg::*;
	import fss_score_model_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int TARGET_ITEMS  = 650;
	// Settling margin after the final transfer, covering the result register.
	localparam int SETTLE_CYCLES = 4;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

	// Byte pools for filler: word boundaries, and bytes at the edges of the letter ranges
	// so that folding is seen to touch letters only.
	localparam string BREAK_CHARS = " -_/.@:";
	localparam string EDGE_CHARS  = "AaZz`{[@Bb";

	typedef enum int {
		CFG_CEILING,
		CFG_FLOOR,
		CFG_RANDOM,
		CFG_RAW
	} cfg_style_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;
	cmd_t                 s_axis_tuser;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [15:0]          m_axis_tdata;
	logic                 m_axis_tuser;

	score_predictor model = new();

	// Bytes appended so far, so that texts can be built around the current query.
	logic [7:0] query_mirror [$];
	int         items_sent = 0;
	int         cycle_count = 0;
	// When set, the sender or the receiver runs without gaps for the current phase.
	bit         tx_steady = 1'b0;
	bit         rx_steady = 1'b0;

	fuzzy_subsequence_scorer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Both streams are sampled in the active region of the edge, so the values seen are
	// those that held before the edge, whatever order the processes run in.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				model.note_command(s_axis_tuser, s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				model.check_verdict(m_axis_tdata, m_axis_tuser);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: before each result it may hold tready low for a random stall, none when
	// running steady, then keeps it high until a transfer takes place.
	initial begin : result_sink
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// One command transfer. tvalid stays high on return, so a following call with no
	// gap presents its item at the very next edge.
	task automatic send_cmd(input cmd_t cmd, input logic [7:0] ch, input logic last);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tuser  <= cmd;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (cmd == CMD_APPEND) begin
			query_mirror.push_back(ch);
		end else if (cmd == CMD_CLEAR) begin
			query_mirror.delete();
		end
	endtask

	function automatic logic [7:0] filler_byte();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0:       c = 8'($urandom());
			1:       c = BREAK_CHARS[$urandom_range(0, BREAK_CHARS.len() - 1)];
			2:       c = "a" + 8'($urandom_range(0, 3));
			default: c = EDGE_CHARS[$urandom_range(0, EDGE_CHARS.len() - 1)];
		endcase
		return c;
	endfunction

	// A text around the current query: each query byte, case flipped at random, is
	// preceded by some filler or by none (a contiguous run). Now and then one byte is
	// dropped, which may leave the query no longer found. The text ends with tlast on its
	// final byte, or with an end command.
	task automatic send_text(input bit well_formed);
		logic [7:0] body [$];
		logic [7:0] c;
		int         n;
		int         i;
		int         k;
		n = (query_mirror.size() > MAX_QUERY) ? MAX_QUERY : query_mirror.size();
		if (well_formed) begin
			for (i = 0; i < n; i++) begin
				k = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
				repeat (k) body.push_back(filler_byte());
				c = query_mirror[i];
				if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1)) begin
					c ^= 8'h20;
				end
				body.push_back(c);
			end
			if (body.size() > 0 && $urandom_range(0, 5) == 0) begin
				body.delete($urandom_range(0, body.size() - 1));
			end
			repeat ($urandom_range(0, 3)) body.push_back(filler_byte());
		end else begin
			repeat ($urandom_range(0, 8)) body.push_back(filler_byte());
		end
		if (body.size() == 0 || $urandom_range(0, 9) < 3) begin
			foreach (body[j]) send_cmd(CMD_TEXT, body[j], 1'b0);
			send_cmd(CMD_END, 8'($urandom()), 1'($urandom()));
		end else begin
			foreach (body[j]) send_cmd(CMD_TEXT, body[j], j == body.size() - 1);
		end
	endtask

	// Registers are only written once every predicted result has left the block and
	// the last command has had time to settle.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (model.verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		model.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_style_t style);
		logic [CFG_DAT_W-1:0] top;
		logic [CFG_DAT_W-1:0] v;
		int                   r;
		for (r = REG_MATCH_POINTS; r <= REG_GAP_CAP; r++) begin
			top = (r == REG_GAP_CAP) ? 8'hFF : (r == REG_GAP_STEP) ? 8'h07 : 8'h1F;
			case (style)
				CFG_CEILING: v = top;
				CFG_FLOOR:   v = '0;
				CFG_RANDOM:  v = 8'($urandom_range(0, top));
				default:     v = 8'($urandom());
			endcase
			write_reg(CFG_IDX_W'(r), v);
		end
		// Raw data also lands on an index that no register answers to.
		if (style == CFG_RAW) begin
			write_reg(REG_UNMAPPED, 8'($urandom()));
		end
	endtask

	initial begin : stimulus
		int phase;
		int episode;
		int qlen;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_CLEAR;
		s_axis_tlast  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An empty query is always found, with a score of zero.
		send_cmd(CMD_END, 8'h00, 1'b0);
		// Clear and append take no notice of tlast; an empty text misses a real query.
		send_cmd(CMD_CLEAR, 8'hFF, 1'b1);
		send_cmd(CMD_APPEND, "a", 1'b1);
		send_cmd(CMD_END, 8'hFF, 1'b1);
		send_cmd(CMD_APPEND, "B", 1'b0);
		send_cmd(CMD_APPEND, "c", 1'b0);
		// First-position bonus, word start after a hyphen, then a contiguous match,
		// all through case folding.
		send_cmd(CMD_TEXT, "A", 1'b0);
		send_cmd(CMD_TEXT, "-", 1'b0);
		send_cmd(CMD_TEXT, "b", 1'b0);
		send_cmd(CMD_TEXT, "C", 1'b1);
		// Gaps at both byte extremes, and a trailing byte once the query is used up.
		send_cmd(CMD_TEXT, 8'h00, 1'b0);
		send_cmd(CMD_TEXT, "a", 1'b0);
		send_cmd(CMD_TEXT, 8'hFF, 1'b0);
		send_cmd(CMD_TEXT, "b", 1'b0);
		send_cmd(CMD_TEXT, "c", 1'b0);
		send_cmd(CMD_TEXT, "Y", 1'b1);
		// Text closed by an end command before the query is complete.
		send_cmd(CMD_TEXT, "a", 1'b0);
		send_cmd(CMD_TEXT, "b", 1'b0);
		send_cmd(CMD_END, 8'h00, 1'b0);
		// An append in the middle of a text abandons it without a result.
		send_cmd(CMD_TEXT, "a", 1'b0);
		send_cmd(CMD_APPEND, "@", 1'b0);
		// Two gaps, then the cap drops below the kept penalty before the text ends.
		send_cmd(CMD_TEXT, "z", 1'b0);
		send_cmd(CMD_TEXT, "Z", 1'b0);
		send_cmd(CMD_TEXT, "a", 1'b0);
		send_cmd(CMD_TEXT, "B", 1'b0);
		send_cmd(CMD_TEXT, "c", 1'b0);
		wait_idle();
		write_reg(REG_GAP_CAP, 8'd1);
		send_cmd(CMD_TEXT, "@", 1'b1);

		// Random phases, each under its own register setting; both extremes come first.
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			wait_idle();
			program_regs(cfg_style_t'(phase % 4));
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			for (episode = 0; episode < 6 && items_sent < TARGET_ITEMS; episode++) begin
				if ($urandom_range(0, 9) < 7) begin
					// Mostly a fresh query, sometimes more bytes on the old one; now and
					// then a query long enough that it can overrun the store.
					if ($urandom_range(0, 3) != 0) begin
						send_cmd(CMD_CLEAR, 8'($urandom()), 1'($urandom()));
					end
					qlen = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70)
					                                      : $urandom_range(0, 6);
					repeat (qlen) send_cmd(CMD_APPEND, filler_byte(), 1'($urandom()));
					repeat ($urandom_range(1, 4)) send_text($urandom_range(0, 6) != 0);
				end else begin
					repeat ($urandom_range(1, 6)) begin
						send_cmd(cmd_t'($urandom_range(0, 3)), 8'($urandom()), 1'($urandom()));
					end
				end
			end
			phase++;
		end

		wait_idle();
		if (model.errors == 0 && model.verdicts.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== fuzzy_subsequence_scorer.f =====
src/fss_pkg.sv
src/fuzzy_subsequence_scorer.sv
test/fss_score_model_pkg.sv
test/fuzzy_subsequence_scorer_tb.sv
